@@ design/snp_allele_to_iupac_code_unit_macros.svh @@
// Assertion helpers used by the design file snp_allele_to_iupac_code_unit.sv.
`ifndef SNP_ALLELE_TO_IUPAC_CODE_UNIT_MACROS_SVH
`define SNP_ALLELE_TO_IUPAC_CODE_UNIT_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define SNP_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check that cond holds in the cycle after trig.
`define SNP_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ design/snpiupac_pkg.sv @@
package snpiupac_pkg;

    // Result kinds carried on the output tuser
    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_INDEL  = 2'd1,
        KIND_ODD    = 2'd2,
        KIND_IUPAC  = 2'd3
    } kind_t;

    // Graphic character range; anything outside ends the string
    localparam logic [7:0] CHAR_FIRST_GRAPHIC = 8'h21;
    localparam logic [7:0] CHAR_LAST_GRAPHIC  = 8'h7E;

    // Input characters that select a class
    localparam logic [7:0] CHAR_A_UP    = 8'h41;
    localparam logic [7:0] CHAR_A_LO    = 8'h61;
    localparam logic [7:0] CHAR_C_UP    = 8'h43;
    localparam logic [7:0] CHAR_C_LO    = 8'h63;
    localparam logic [7:0] CHAR_G_UP    = 8'h47;
    localparam logic [7:0] CHAR_G_LO    = 8'h67;
    localparam logic [7:0] CHAR_T_UP    = 8'h54;
    localparam logic [7:0] CHAR_T_LO    = 8'h74;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_BRK_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_BRK_CLOSE = 8'h5D;

    // Output codes
    localparam logic [7:0] CODE_INDEL = 8'h2D;  // '-'
    localparam logic [7:0] CODE_ODD   = 8'h78;  // 'x'
    localparam logic [7:0] CODE_M     = 8'h4D;
    localparam logic [7:0] CODE_R     = 8'h52;
    localparam logic [7:0] CODE_W     = 8'h57;
    localparam logic [7:0] CODE_S     = 8'h53;
    localparam logic [7:0] CODE_Y     = 8'h59;
    localparam logic [7:0] CODE_K     = 8'h4B;

endpackage

@@ design/snp_allele_to_iupac_code_unit.sv @@
// Channel   | Direction | Payload
// ----------+-----------+-------------------------------------------
// s_axis    | in        | tdata[7:0] = ch
// m_axis    | out       | tdata[7:0] = code, tuser[1:0] = kind
//
// One character per cycle is taken; class counters update in the accepting cycle.
// A terminator is decoded from the counters straight into the result register,
// so its transaction appears on m_axis the cycle after it is accepted.
// The result register is the only stall point: s_axis stalls only while a result
// waits and m_axis_tready is low. Reset clears all counters and the held character.
`include "snp_allele_to_iupac_code_unit_macros.svh"

module snp_allele_to_iupac_code_unit #(
    parameter int COUNT_WIDTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] code
    output logic [1:0] m_axis_tuser    // [1:0] kind
);

    localparam int SUM_W = COUNT_WIDTH + 3;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

    logic [COUNT_WIDTH-1:0] cnt_a_reg, cnt_a_next;
    logic [COUNT_WIDTH-1:0] cnt_c_reg, cnt_c_next;
    logic [COUNT_WIDTH-1:0] cnt_g_reg, cnt_g_next;
    logic [COUNT_WIDTH-1:0] cnt_t_reg, cnt_t_next;
    logic [COUNT_WIDTH-1:0] cnt_del_reg, cnt_del_next;
    logic [COUNT_WIDTH-1:0] cnt_sep_reg, cnt_sep_next;
    logic [COUNT_WIDTH-1:0] cnt_other_reg, cnt_other_next;
    logic [7:0]             held_reg, held_next;

    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             code_reg, code_next;
    snpiupac_pkg::kind_t    kind_reg, kind_next;

    logic                   in_fire;
    logic                   is_term;
    logic [SUM_W-1:0]       base_sum;
    logic [SUM_W-1:0]       char_sum;
    logic                   dec_single;
    logic                   dec_indel;
    logic                   dec_odd;
    logic [7:0]             pair_code;

    // Accept while the result register is empty or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign is_term       = (s_axis_tdata < snpiupac_pkg::CHAR_FIRST_GRAPHIC)
                        || (s_axis_tdata > snpiupac_pkg::CHAR_LAST_GRAPHIC);

    // Classify the character and bump its saturating counter; a terminator clears all counters
    always_comb
    begin
        cnt_a_next     = cnt_a_reg;
        cnt_c_next     = cnt_c_reg;
        cnt_g_next     = cnt_g_reg;
        cnt_t_next     = cnt_t_reg;
        cnt_del_next   = cnt_del_reg;
        cnt_sep_next   = cnt_sep_reg;
        cnt_other_next = cnt_other_reg;
        held_next      = held_reg;
        if (in_fire)
        begin
            if (is_term)
            begin
                cnt_a_next     = CNT_ZERO;
                cnt_c_next     = CNT_ZERO;
                cnt_g_next     = CNT_ZERO;
                cnt_t_next     = CNT_ZERO;
                cnt_del_next   = CNT_ZERO;
                cnt_sep_next   = CNT_ZERO;
                cnt_other_next = CNT_ZERO;
                held_next      = 8'h00;
            end
            else
            begin
                case (s_axis_tdata)
                    snpiupac_pkg::CHAR_A_UP, snpiupac_pkg::CHAR_A_LO:
                    begin
                        if (cnt_a_reg != CNT_MAX) cnt_a_next = cnt_a_reg + CNT_ONE;
                        held_next = s_axis_tdata;
                    end
                    snpiupac_pkg::CHAR_C_UP, snpiupac_pkg::CHAR_C_LO:
                    begin
                        if (cnt_c_reg != CNT_MAX) cnt_c_next = cnt_c_reg + CNT_ONE;
                        held_next = s_axis_tdata;
                    end
                    snpiupac_pkg::CHAR_G_UP, snpiupac_pkg::CHAR_G_LO:
                    begin
                        if (cnt_g_reg != CNT_MAX) cnt_g_next = cnt_g_reg + CNT_ONE;
                        held_next = s_axis_tdata;
                    end
                    snpiupac_pkg::CHAR_T_UP, snpiupac_pkg::CHAR_T_LO:
                    begin
                        if (cnt_t_reg != CNT_MAX) cnt_t_next = cnt_t_reg + CNT_ONE;
                        held_next = s_axis_tdata;
                    end
                    snpiupac_pkg::CHAR_STAR, snpiupac_pkg::CHAR_DASH:
                    begin
                        if (cnt_del_reg != CNT_MAX) cnt_del_next = cnt_del_reg + CNT_ONE;
                    end
                    snpiupac_pkg::CHAR_SLASH:
                    begin
                        if (cnt_sep_reg != CNT_MAX) cnt_sep_next = cnt_sep_reg + CNT_ONE;
                    end
                    snpiupac_pkg::CHAR_BRK_OPEN, snpiupac_pkg::CHAR_BRK_CLOSE:
                    begin
                        // brackets are ignored
                    end
                    default:
                    begin
                        if (cnt_other_reg != CNT_MAX) cnt_other_next = cnt_other_reg + CNT_ONE;
                        held_next = s_axis_tdata;
                    end
                endcase
            end
        end
    end

    // Count totals used by the decode
    assign base_sum = SUM_W'(cnt_a_reg) + SUM_W'(cnt_c_reg)
                    + SUM_W'(cnt_g_reg) + SUM_W'(cnt_t_reg);
    assign char_sum = base_sum + SUM_W'(cnt_other_reg);

    assign dec_single = (char_sum == SUM_W'(1)) && (cnt_del_reg == CNT_ZERO)
                     && (cnt_sep_reg == CNT_ZERO);
    assign dec_indel  = (cnt_del_reg == CNT_ONE) && (base_sum != '0)
                     && (cnt_sep_reg != CNT_ZERO) && (cnt_other_reg == CNT_ZERO);
    assign dec_odd    = (cnt_sep_reg != CNT_ONE) || (base_sum != SUM_W'(2))
                     || (cnt_other_reg != CNT_ZERO) || (cnt_del_reg != CNT_ZERO);

    // Pick the two-base letter; a repeated base gives its upper-case letter
    always_comb
    begin
        if (cnt_a_reg != CNT_ZERO)
        begin
            if (cnt_c_reg != CNT_ZERO)      pair_code = snpiupac_pkg::CODE_M;
            else if (cnt_g_reg != CNT_ZERO) pair_code = snpiupac_pkg::CODE_R;
            else if (cnt_t_reg != CNT_ZERO) pair_code = snpiupac_pkg::CODE_W;
            else                            pair_code = snpiupac_pkg::CHAR_A_UP;
        end
        else if (cnt_c_reg != CNT_ZERO)
        begin
            if (cnt_g_reg != CNT_ZERO)      pair_code = snpiupac_pkg::CODE_S;
            else if (cnt_t_reg != CNT_ZERO) pair_code = snpiupac_pkg::CODE_Y;
            else                            pair_code = snpiupac_pkg::CHAR_C_UP;
        end
        else if (cnt_g_reg != CNT_ZERO)
        begin
            if (cnt_t_reg != CNT_ZERO)      pair_code = snpiupac_pkg::CODE_K;
            else                            pair_code = snpiupac_pkg::CHAR_G_UP;
        end
        else
        begin
            pair_code = snpiupac_pkg::CHAR_T_UP;
        end
    end

    // Load the result register on a terminator, drain it on the output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        code_next      = code_reg;
        kind_next      = kind_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire && is_term)
        begin
            out_valid_next = 1'b1;
            if (dec_single)
            begin
                code_next = held_reg;
                kind_next = snpiupac_pkg::KIND_SINGLE;
            end
            else if (dec_indel)
            begin
                code_next = snpiupac_pkg::CODE_INDEL;
                kind_next = snpiupac_pkg::KIND_INDEL;
            end
            else if (dec_odd)
            begin
                code_next = snpiupac_pkg::CODE_ODD;
                kind_next = snpiupac_pkg::KIND_ODD;
            end
            else
            begin
                code_next = pair_code;
                kind_next = snpiupac_pkg::KIND_IUPAC;
            end
        end
    end

    // Control and string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg     <= '0;
            cnt_c_reg     <= '0;
            cnt_g_reg     <= '0;
            cnt_t_reg     <= '0;
            cnt_del_reg   <= '0;
            cnt_sep_reg   <= '0;
            cnt_other_reg <= '0;
            held_reg      <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_a_reg     <= cnt_a_next;
            cnt_c_reg     <= cnt_c_next;
            cnt_g_reg     <= cnt_g_next;
            cnt_t_reg     <= cnt_t_next;
            cnt_del_reg   <= cnt_del_next;
            cnt_sep_reg   <= cnt_sep_next;
            cnt_other_reg <= cnt_other_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        kind_reg <= kind_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = code_reg;
    assign m_axis_tuser  = kind_reg;

    // Checks on terminator handling and the result decode
    `SNP_ASSERT_NEXT(a_term_gives_result, clk, rst_n, in_fire && is_term, out_valid_reg, "terminator gave no result")
    `SNP_ASSERT_NEXT(a_term_clears_state, clk, rst_n, in_fire && is_term, (cnt_sep_reg == CNT_ZERO) && (cnt_del_reg == CNT_ZERO) && (held_reg == 8'h00), "state not cleared after terminator")
    `SNP_ASSERT_SAME(a_pair_letter, clk, rst_n, out_valid_reg && (kind_reg == snpiupac_pkg::KIND_IUPAC), (code_reg == snpiupac_pkg::CODE_M) || (code_reg == snpiupac_pkg::CODE_R) || (code_reg == snpiupac_pkg::CODE_W) || (code_reg == snpiupac_pkg::CODE_S) || (code_reg == snpiupac_pkg::CODE_Y) || (code_reg == snpiupac_pkg::CODE_K) || (code_reg == snpiupac_pkg::CHAR_A_UP) || (code_reg == snpiupac_pkg::CHAR_C_UP) || (code_reg == snpiupac_pkg::CHAR_G_UP) || (code_reg == snpiupac_pkg::CHAR_T_UP), "two-base result has a bad letter")

endmodule

@@ verif/snp_allele_to_iupac_code_unit_test.sv @@
`timescale 1ns / 1ps

// Scoreboard: tracks the class counters of the current allele string and
// queues the code each terminator should produce.
class iupac_scoreboard;
    localparam int CNT_W = 4;

    logic [CNT_W-1:0] n_a;
    logic [CNT_W-1:0] n_c;
    logic [CNT_W-1:0] n_g;
    logic [CNT_W-1:0] n_t;
    logic [CNT_W-1:0] n_del;
    logic [CNT_W-1:0] n_sep;
    logic [CNT_W-1:0] n_oth;
    logic [7:0] held_ch;
    logic [7:0] code_q[$];
    snpiupac_pkg::kind_t kind_q[$];
    int errors;

    function new();
        errors = 0;
        clear_counts();
    endfunction

    function void clear_counts();
        n_a = '0;
        n_c = '0;
        n_g = '0;
        n_t = '0;
        n_del = '0;
        n_sep = '0;
        n_oth = '0;
        held_ch = 8'h00;
    endfunction

    // Saturating increment
    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] cnt);
        return (cnt == '1) ? cnt : cnt + 1'b1;
    endfunction

    // Collapse the counters into one code and kind
    function void decode_allele(output logic [7:0] code,
                                output snpiupac_pkg::kind_t kind);
        int nb;
        nb = int'(n_a) + int'(n_c) + int'(n_g) + int'(n_t);
        if (nb + int'(n_oth) == 1 && n_del == 0 && n_sep == 0)
        begin
            code = held_ch;
            kind = snpiupac_pkg::KIND_SINGLE;
        end
        else if (n_del == 1 && nb > 0 && n_sep > 0 && n_oth == 0)
        begin
            code = snpiupac_pkg::CODE_INDEL;
            kind = snpiupac_pkg::KIND_INDEL;
        end
        else if (n_sep != 1 || nb != 2 || n_oth > 0 || n_del > 0)
        begin
            code = snpiupac_pkg::CODE_ODD;
            kind = snpiupac_pkg::KIND_ODD;
        end
        else
        begin
            kind = snpiupac_pkg::KIND_IUPAC;
            if (n_a != 0)
            begin
                if (n_c != 0)      code = snpiupac_pkg::CODE_M;
                else if (n_g != 0) code = snpiupac_pkg::CODE_R;
                else if (n_t != 0) code = snpiupac_pkg::CODE_W;
                else               code = snpiupac_pkg::CHAR_A_UP;
            end
            else if (n_c != 0)
            begin
                if (n_g != 0)      code = snpiupac_pkg::CODE_S;
                else if (n_t != 0) code = snpiupac_pkg::CODE_Y;
                else               code = snpiupac_pkg::CHAR_C_UP;
            end
            else if (n_g != 0)
            begin
                if (n_t != 0)      code = snpiupac_pkg::CODE_K;
                else               code = snpiupac_pkg::CHAR_G_UP;
            end
            else
            begin
                code = snpiupac_pkg::CHAR_T_UP;
            end
        end
    endfunction

    // Account for one accepted character
    function void note_char(logic [7:0] ch);
        logic [7:0] code;
        snpiupac_pkg::kind_t kind;
        if (ch < snpiupac_pkg::CHAR_FIRST_GRAPHIC || ch > snpiupac_pkg::CHAR_LAST_GRAPHIC)
        begin
            decode_allele(code, kind);
            code_q.push_back(code);
            kind_q.push_back(kind);
            clear_counts();
            return;
        end
        case (ch)
            snpiupac_pkg::CHAR_A_UP, snpiupac_pkg::CHAR_A_LO:
            begin
                n_a = bump(n_a);
                held_ch = ch;
            end
            snpiupac_pkg::CHAR_C_UP, snpiupac_pkg::CHAR_C_LO:
            begin
                n_c = bump(n_c);
                held_ch = ch;
            end
            snpiupac_pkg::CHAR_G_UP, snpiupac_pkg::CHAR_G_LO:
            begin
                n_g = bump(n_g);
                held_ch = ch;
            end
            snpiupac_pkg::CHAR_T_UP, snpiupac_pkg::CHAR_T_LO:
            begin
                n_t = bump(n_t);
                held_ch = ch;
            end
            snpiupac_pkg::CHAR_STAR, snpiupac_pkg::CHAR_DASH:
                n_del = bump(n_del);
            snpiupac_pkg::CHAR_SLASH:
                n_sep = bump(n_sep);
            snpiupac_pkg::CHAR_BRK_OPEN, snpiupac_pkg::CHAR_BRK_CLOSE:
                ;
            default:
            begin
                n_oth = bump(n_oth);
                held_ch = ch;
            end
        endcase
    endfunction

    // Compare one output transaction against the oldest expected code
    function void check_result(logic [7:0] code, logic [1:0] kind);
        logic [7:0] exp_code;
        logic [1:0] exp_kind;
        if (code_q.size() == 0)
        begin
            $error("unexpected result: code %h kind %0d", code, kind);
            errors++;
            return;
        end
        exp_code = code_q.pop_front();
        exp_kind = kind_q.pop_front();
        if (code !== exp_code)
        begin
            $error("code mismatch: expected %h actual %h", exp_code, code);
            errors++;
        end
        if (kind !== exp_kind)
        begin
            $error("kind mismatch: expected %0d actual %0d", exp_kind, kind);
            errors++;
        end
    endfunction

    function int pending();
        return code_q.size();
    endfunction
endclass

module snp_allele_to_iupac_code_unit_test;

    localparam int ITEM_TARGET = 450;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] ch
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] code
    logic [1:0] m_axis_tuser;           // [1:0] kind

    iupac_scoreboard sb = new();
    bit  steady_run = 1'b0;
    bit  hold_off_req = 1'b0;
    int  cycle_cnt = 0;
    int  item_cnt = 0;
    logic [7:0] allele_q[$];

    snp_allele_to_iupac_code_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Check every accepted output transaction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            gap = steady_run ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Offer one character and hold it until the block takes it
    task automatic send_char(input logic [7:0] ch);
        int gap;
        gap = steady_run ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_char(ch);
        if (ch != snpiupac_pkg::CHAR_BRK_OPEN && ch != snpiupac_pkg::CHAR_BRK_CLOSE)
            item_cnt++;
    endtask

    // Stop offering until every expected code has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_allele();
        while (allele_q.size() != 0)
            send_char(allele_q.pop_front());
    endtask

    function automatic logic [7:0] pick_base();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0: b = snpiupac_pkg::CHAR_A_UP;
            1: b = snpiupac_pkg::CHAR_C_UP;
            2: b = snpiupac_pkg::CHAR_G_UP;
            default: b = snpiupac_pkg::CHAR_T_UP;
        endcase
        if ($urandom_range(0, 1) == 1)
            b = b | 8'h20;
        return b;
    endfunction

    function automatic logic [7:0] pick_del();
        return ($urandom_range(0, 1) == 1) ? snpiupac_pkg::CHAR_STAR : snpiupac_pkg::CHAR_DASH;
    endfunction

    function automatic logic [7:0] pick_term();
        if ($urandom_range(0, 1) == 1)
            return 8'($urandom_range(0, 8'h20));
        return 8'($urandom_range(8'h7F, 8'hFF));
    endfunction

    // Any graphic character
    function automatic logic [7:0] pick_graphic();
        return 8'($urandom_range(snpiupac_pkg::CHAR_FIRST_GRAPHIC,
                                 snpiupac_pkg::CHAR_LAST_GRAPHIC));
    endfunction

    // Any character an allele string tends to contain
    function automatic logic [7:0] pick_allele_char();
        case ($urandom_range(0, 7))
            0, 1, 2: return pick_base();
            3: return snpiupac_pkg::CHAR_SLASH;
            4: return pick_del();
            5: return ($urandom_range(0, 1) == 1) ? snpiupac_pkg::CHAR_BRK_OPEN
                                                  : snpiupac_pkg::CHAR_BRK_CLOSE;
            default: return pick_graphic();
        endcase
    endfunction

    // Build one random allele string followed by a terminator
    task automatic build_allele();
        bit brk;
        int len;
        logic [7:0] ch;
        brk = ($urandom_range(0, 1) == 1);
        if (brk)
            allele_q.push_back(snpiupac_pkg::CHAR_BRK_OPEN);
        case ($urandom_range(0, 9))
            0, 1:
                allele_q.push_back(pick_base());
            2, 3, 4:
            begin
                allele_q.push_back(pick_base());
                allele_q.push_back(snpiupac_pkg::CHAR_SLASH);
                allele_q.push_back(pick_base());
            end
            5:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    allele_q.push_back(pick_base());
                    allele_q.push_back(snpiupac_pkg::CHAR_SLASH);
                    allele_q.push_back(pick_del());
                end
                else
                begin
                    allele_q.push_back(pick_del());
                    allele_q.push_back(snpiupac_pkg::CHAR_SLASH);
                    allele_q.push_back(pick_base());
                end
            end
            6:
                allele_q.push_back(pick_graphic());
            7:
            begin
                len = $urandom_range(0, 6);
                repeat (len) allele_q.push_back(pick_graphic());
            end
            8:
            begin
                // broken or near-miss allele strings
                len = $urandom_range(1, 6);
                repeat (len) allele_q.push_back(pick_allele_char());
            end
            default:
            begin
                // long runs push a counter into saturation
                ch = pick_allele_char();
                len = $urandom_range(15, 20);
                repeat (len) allele_q.push_back(ch);
                if ($urandom_range(0, 1) == 1)
                begin
                    allele_q.push_back(snpiupac_pkg::CHAR_SLASH);
                    allele_q.push_back(pick_base());
                end
            end
        endcase
        if (brk)
            allele_q.push_back(snpiupac_pkg::CHAR_BRK_CLOSE);
        allele_q.push_back(pick_term());
    endtask

    initial
    begin
        int n_str;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings
        allele_q = '{8'h61, 8'h00,
                     8'h20,
                     8'h41, 8'h2F, 8'h67, 8'hFF,
                     8'h5B, 8'h63, 8'h5D, 8'h7F,
                     8'h43, 8'h2F, 8'h2D, 8'h21 - 8'h01,
                     8'h74, 8'h2F, 8'h54, 8'h0A,
                     8'h21, 8'h7E, 8'h0D};
        send_allele();
        drain_results();

        // Random strings
        n_str = 0;
        while (item_cnt < ITEM_TARGET)
        begin
            if (n_str == 25)
                hold_off_req = 1'b1;
            if (n_str == 50)
                steady_run = 1'b1;
            if (n_str == 70)
                steady_run = 1'b0;
            if (n_str % 40 == 30)
                drain_results();
            build_allele();
            send_allele();
            n_str++;
        end

        // Let the block flush its last code
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+design
design/snpiupac_pkg.sv
design/snp_allele_to_iupac_code_unit.sv
verif/snp_allele_to_iupac_code_unit_test.sv
